/* hdl/ldlpc_pkg.sv */
// Shared constants, types and controller commands of the Levinson-Durbin LPC solver.
// Depends on nothing; every other file of the block but the channel interfaces imports it.
`default_nettype none
package ldlpc_pkg;

	localparam int MAX_ORDER = 32;
	localparam int DEPTH = MAX_ORDER + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int DATA_W = 32;
	localparam int SUM_W = 48;
	localparam int ERR_W = 35;
	localparam int REM_W = 34;
	localparam int QUO_W = 31;
	localparam int DIV_STEPS = QUO_W;
	localparam int F30_W = 34;
	localparam int SAT_W = 35;
	localparam int PRED_W = 31;
	localparam int DCW = $clog2(DIV_STEPS);

	localparam logic [5:0] ORDER_RESET = 6'd22;
	localparam logic signed [DATA_W-1:0] ONE_Q23 = 32'sh0080_0000;
	localparam logic signed [DATA_W-1:0] LAM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] LAM_MIN = 32'sh8000_0000;
	localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

	typedef enum logic [1:0] {
		SRC_ONE,
		SRC_LO,
		SRC_HI,
		SRC_AI
	} coef_src_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_INIT2,
		ST_STEP,
		ST_SUM_RD,
		ST_SUM_MUL,
		ST_SUM_ACC,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_FIN,
		ST_UPD_RD,
		ST_UPD_MUL,
		ST_UPD_WR1,
		ST_UPD_WR2,
		ST_AI_WR,
		ST_ERR_F,
		ST_ERR_MUL,
		ST_ERR_UPD,
		ST_FIN,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	typedef struct packed {
		logic          corr_we;
		logic [AW-1:0] corr_addr;
		logic          coef_we;
		coef_src_t     coef_src;
		logic [AW-1:0] coef_waddr;
		logic [AW-1:0] coef_ra;
		logic [AW-1:0] coef_rb;
		logic          err_ld;
		logic          sum_clr;
		logic          sum_mul;
		logic          sum_acc;
		logic          div_init;
		logic          div_step;
		logic          div_fin;
		logic          lam_zero;
		logic          upd_mul;
		logic          ovf_clr;
		logic          fsq_ld;
		logic          f30_ld;
		logic          emul_ld;
		logic          err_upd;
		logic          unst_clr;
		logic          unst_chk;
		logic          out_ld;
		logic          out_last;
		logic [AW-1:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic err_nonpos;
		logic div_sat;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

/* hdl/ldlpc_ifs.sv */
// Handshake channel interfaces of the LPC solver: correlation input, coefficient
// output and the order register write. Depends on nothing.
`default_nettype none
interface ldlpc_corr_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] corr_value;
	modport source (output valid, output corr_value, input ready);
	modport sink (input valid, input corr_value, output ready);
endinterface

interface ldlpc_coef_if;
	logic               valid;
	logic               ready;
	logic [5:0]         coef_index;
	logic signed [31:0] coef_value;
	logic [30:0]        pred_error;
	logic               last_coef;
	logic               overflow;
	logic               unstable;
	modport source (output valid, output coef_index, output coef_value, output pred_error,
		output last_coef, output overflow, output unstable, input ready);
	modport sink (input valid, input coef_index, input coef_value, input pred_error,
		input last_coef, input overflow, input unstable, output ready);
endinterface

interface ldlpc_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] order;
	modport source (output valid, output order, input ready);
	modport sink (input valid, input order, output ready);
endinterface
`default_nettype wire

/* hdl/levinson_durbin_lpc_solver.sv */
// Top level of the Levinson-Durbin LPC solver: joins the sequencer and the datapath.
// Depends on ldlpc_pkg, the channel interfaces, ldlpc_ctrl and ldlpc_dp.
//
// Usage: autocorrelation values r[0..order] arrive on the corr channel, one per
// transfer, as signed Q1.30. The order register is written through the cfg
// channel, which is always ready; write it only while no run is in progress.
// An order of 0 is run as 1 and one above 32 as 32, also for loads and results.
// The corr channel stays ready throughout loading. When the last value is in,
// the solver runs the recursion alone: step i forms the correlation sum term by
// term (one shared multiplier and accumulator), finds lambda with a restoring
// divider producing one quotient bit per cycle, updates the coefficients in
// symmetric pairs (one write port on the coefficient memory) and updates the error.
// The solver then offers order+1 results on the coef channel, a[0] first, the next
// once the one before is taken; the last carries the final prediction error.
// The corr channel is not ready during the solve and while results are sent; it
// becomes ready again once the last result is in the output register.
// A stalled receiver simply holds the output register and the sequencer waits.
// Reset clears the load count, the flags and sets the order to 22; the memory
// contents are not cleared and need no clearing.
`default_nettype none
module levinson_durbin_lpc_solver (
	input  wire          clk,
	input  wire          arst_n,
	ldlpc_corr_if.sink   corr,
	ldlpc_coef_if.source coef,
	ldlpc_cfg_if.sink    cfg
);
	import ldlpc_pkg::*;

	cmd_t cmd;
	status_t status;

	// The order register takes every write in the cycle it is offered.
	assign cfg.ready = 1'b1;

	ldlpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (corr.valid),
		.in_ready  (corr.ready),
		.cfg_valid (cfg.valid),
		.cfg_order (cfg.order),
		.status    (status),
		.cmd       (cmd)
	);

	ldlpc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (corr.corr_value),
		.cmd     (cmd),
		.status  (status),
		.out     (coef)
	);

endmodule
`default_nettype wire

/* hdl/ldlpc_ctrl.sv */
// Sequencer of the LPC solver: loads, recursion steps, division and output pacing.
// Depends on ldlpc_pkg; drives the datapath through cmd_t.
`default_nettype none
module ldlpc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  cfg_valid,
	input  wire  [5:0]           cfg_order,
	input  ldlpc_pkg::status_t   status,
	output ldlpc_pkg::cmd_t      cmd
);
	import ldlpc_pkg::*;

	state_t state_q, state_d;
	logic [5:0] order_q;
	logic [AW-1:0] n_q, i_q, j_q, k_q, load_q;
	logic [DCW-1:0] dcnt_q;
	logic [AW-1:0] n_eff, load_idx, i_minus_j;
	logic accept;

	always_comb begin
		n_eff = order_q[AW-1:0];
		if (order_q == 6'd0) begin
			n_eff = AW'(1);
		end else if (order_q > 6'(MAX_ORDER)) begin
			n_eff = AW'(MAX_ORDER);
		end
	end

	assign load_idx = (load_q > AW'(MAX_ORDER)) ? '0 : load_q;
	assign i_minus_j = i_q - j_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_ready && in_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (load_idx + AW'(1) >= n_eff + AW'(1))) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: state_d = ST_INIT2;
			ST_INIT2: state_d = ST_STEP;
			ST_STEP: begin
				if (status.err_nonpos) begin
					state_d = (i_q >= AW'(2)) ? ST_UPD_RD : ST_AI_WR;
				end else begin
					state_d = ST_SUM_RD;
				end
			end
			ST_SUM_RD: state_d = ST_SUM_MUL;
			ST_SUM_MUL: state_d = ST_SUM_ACC;
			ST_SUM_ACC: state_d = (j_q == i_q) ? ST_DIV_INIT : ST_SUM_RD;
			ST_DIV_INIT: begin
				if (status.div_sat) begin
					state_d = (i_q >= AW'(2)) ? ST_UPD_RD : ST_AI_WR;
				end else begin
					state_d = ST_DIV_STEP;
				end
			end
			ST_DIV_STEP: state_d = (dcnt_q == DCW'(DIV_STEPS - 1)) ? ST_DIV_FIN : ST_DIV_STEP;
			ST_DIV_FIN: state_d = (i_q >= AW'(2)) ? ST_UPD_RD : ST_AI_WR;
			ST_UPD_RD: state_d = ST_UPD_MUL;
			ST_UPD_MUL: state_d = ST_UPD_WR1;
			ST_UPD_WR1: state_d = ST_UPD_WR2;
			ST_UPD_WR2: state_d = (j_q == (i_q >> 1)) ? ST_AI_WR : ST_UPD_RD;
			ST_AI_WR: state_d = ST_ERR_F;
			ST_ERR_F: state_d = ST_ERR_MUL;
			ST_ERR_MUL: state_d = ST_ERR_UPD;
			ST_ERR_UPD: state_d = (i_q == n_q) ? ST_FIN : ST_STEP;
			ST_FIN: state_d = ST_OUT_RD;
			ST_OUT_RD: state_d = status.out_busy ? ST_OUT_RD : ST_OUT_LD;
			ST_OUT_LD: state_d = (k_q == n_q) ? ST_IDLE : ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.coef_src = SRC_ONE;
		cmd.corr_addr = j_q;
		cmd.coef_ra = i_minus_j;
		cmd.coef_rb = i_minus_j;
		cmd.coef_waddr = j_q;
		cmd.out_idx = k_q;
		case (state_q)
			ST_IDLE: begin
				cmd.corr_addr = load_idx;
				cmd.corr_we = accept;
			end
			ST_INIT: begin
				cmd.corr_addr = '0;
				cmd.coef_we = 1'b1;
				cmd.coef_src = SRC_ONE;
				cmd.coef_waddr = '0;
				cmd.ovf_clr = 1'b1;
				cmd.unst_clr = 1'b1;
			end
			ST_INIT2: cmd.err_ld = 1'b1;
			ST_STEP: begin
				cmd.unst_chk = 1'b1;
				cmd.lam_zero = status.err_nonpos;
				cmd.sum_clr = 1'b1;
			end
			ST_SUM_MUL: cmd.sum_mul = 1'b1;
			ST_SUM_ACC: cmd.sum_acc = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV_STEP: cmd.div_step = 1'b1;
			ST_DIV_FIN: cmd.div_fin = 1'b1;
			ST_UPD_RD: cmd.coef_ra = j_q;
			ST_UPD_MUL: cmd.upd_mul = 1'b1;
			ST_UPD_WR1: begin
				cmd.coef_we = 1'b1;
				cmd.coef_src = SRC_LO;
				cmd.coef_waddr = j_q;
			end
			ST_UPD_WR2: begin
				cmd.coef_we = 1'b1;
				cmd.coef_src = SRC_HI;
				cmd.coef_waddr = i_minus_j;
			end
			ST_AI_WR: begin
				cmd.coef_we = 1'b1;
				cmd.coef_src = SRC_AI;
				cmd.coef_waddr = i_q;
				cmd.fsq_ld = 1'b1;
			end
			ST_ERR_F: cmd.f30_ld = 1'b1;
			ST_ERR_MUL: cmd.emul_ld = 1'b1;
			ST_ERR_UPD: cmd.err_upd = 1'b1;
			ST_FIN: cmd.unst_chk = 1'b1;
			ST_OUT_RD: cmd.coef_ra = k_q;
			ST_OUT_LD: begin
				cmd.coef_ra = k_q;
				cmd.out_ld = 1'b1;
				cmd.out_last = (k_q == n_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= ORDER_RESET;
			n_q <= AW'(1);
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			load_q <= '0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				order_q <= cfg_order;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (load_idx + AW'(1) >= n_eff + AW'(1)) begin
							load_q <= '0;
							n_q <= n_eff;
							i_q <= AW'(1);
						end else begin
							load_q <= load_idx + AW'(1);
						end
					end
				end
				ST_STEP: j_q <= AW'(1);
				ST_SUM_ACC: begin
					if (j_q == i_q) begin
						j_q <= AW'(1);
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_DIV_INIT: dcnt_q <= '0;
				ST_DIV_STEP: dcnt_q <= dcnt_q + DCW'(1);
				ST_UPD_WR2: j_q <= j_q + AW'(1);
				ST_ERR_UPD: i_q <= i_q + AW'(1);
				ST_FIN: k_q <= '0;
				ST_OUT_LD: k_q <= k_q + AW'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/ldlpc_dp.sv */
// Datapath of the LPC solver: correlation and coefficient memories, multipliers,
// the restoring divider for lambda, error update and the output register. Uses ldlpc_pkg.
`default_nettype none
module ldlpc_dp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  signed [31:0]    in_data,
	input  ldlpc_pkg::cmd_t       cmd,
	output ldlpc_pkg::status_t    status,
	ldlpc_coef_if.source          out
);
	import ldlpc_pkg::*;

	logic signed [DATA_W-1:0] corr_mem [DEPTH];
	logic signed [DATA_W-1:0] coef_mem [DEPTH];
	logic signed [DATA_W-1:0] corr_rd_q, coef_rda_q, coef_rdb_q;
	logic signed [63:0] prod_q, m1_q, m2_q, fsq_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [DATA_W-1:0] lam_q, lo_q, hi_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic neg_q;
	logic signed [F30_W-1:0] f30_q;
	logic signed [ERR_W+F30_W-1:0] emul_q;
	logic [DEPTH-1:0] ovf_q;
	logic unstable_q;
	logic out_valid_q;

	logic signed [SUM_W-1:0] num;
	logic [SUM_W-1:0] mag, err2;
	logic [REM_W-1:0] err_u, rem_sub;
	logic rem_ge;
	logic signed [SAT_W-1:0] nlo_w, nhi_w;
	logic hit_lo, hit_hi;
	logic signed [DATA_W-1:0] nlo, nhi, coef_wdata;

	assign num = -sum_q;
	assign mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
	assign err2 = SUM_W'({err_q, 1'b0});
	assign err_u = err_q[REM_W-1:0];
	assign rem_ge = rem_q >= err_u;
	assign rem_sub = rem_ge ? rem_q - err_u : rem_q;

	assign nlo_w = SAT_W'(lo_q) + SAT_W'(m1_q >>> 30);
	assign nhi_w = SAT_W'(hi_q) + SAT_W'(m2_q >>> 30);
	assign hit_lo = nlo_w[SAT_W-1:DATA_W-1] != {(SAT_W-DATA_W+1){nlo_w[DATA_W-1]}};
	assign hit_hi = nhi_w[SAT_W-1:DATA_W-1] != {(SAT_W-DATA_W+1){nhi_w[DATA_W-1]}};
	assign nlo = hit_lo ? (nlo_w[SAT_W-1] ? LAM_MIN : LAM_MAX) : nlo_w[DATA_W-1:0];
	assign nhi = hit_hi ? (nhi_w[SAT_W-1] ? LAM_MIN : LAM_MAX) : nhi_w[DATA_W-1:0];

	always_comb begin
		case (cmd.coef_src)
			SRC_ONE: coef_wdata = ONE_Q23;
			SRC_LO: coef_wdata = nlo;
			SRC_HI: coef_wdata = nhi;
			SRC_AI: coef_wdata = lam_q >>> 7;
			default: coef_wdata = ONE_Q23;
		endcase
	end

	assign status.err_nonpos = (err_q <= 0);
	assign status.div_sat = (mag >= err2);
	assign status.out_busy = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.corr_we) begin
			corr_mem[cmd.corr_addr] <= in_data;
		end
		corr_rd_q <= corr_mem[cmd.corr_addr];
		if (cmd.coef_we) begin
			coef_mem[cmd.coef_waddr] <= coef_wdata;
		end
		coef_rda_q <= coef_mem[cmd.coef_ra];
		coef_rdb_q <= coef_mem[cmd.coef_rb];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_mul) begin
			prod_q <= corr_rd_q * coef_rda_q;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_acc) begin
			sum_q <= sum_q + SUM_W'(prod_q >>> 23);
		end
		if (cmd.lam_zero) begin
			lam_q <= '0;
		end else if (cmd.div_init) begin
			lam_q <= (sum_q < 0) ? LAM_MAX : LAM_MIN;
			rem_q <= mag[REM_W-1:0];
			quo_q <= '0;
			neg_q <= (sum_q > 0);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
		end else if (cmd.div_fin) begin
			lam_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		end
		if (cmd.upd_mul) begin
			m1_q <= lam_q * coef_rdb_q;
			m2_q <= lam_q * coef_rda_q;
			lo_q <= coef_rda_q;
			hi_q <= coef_rdb_q;
		end
		if (cmd.fsq_ld) begin
			fsq_q <= lam_q * lam_q;
		end
		if (cmd.f30_ld) begin
			f30_q <= F30_W'((ONE_Q60 - fsq_q) >>> 30);
		end
		if (cmd.emul_ld) begin
			emul_q <= err_q * f30_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
			ovf_q <= '0;
			unstable_q <= 1'b0;
		end else begin
			if (cmd.err_ld) begin
				err_q <= ERR_W'(corr_rd_q);
			end else if (cmd.err_upd) begin
				err_q <= ERR_W'(emul_q >>> 30);
			end
			if (cmd.ovf_clr) begin
				ovf_q <= '0;
			end else if (cmd.coef_we && cmd.coef_src == SRC_LO && hit_lo) begin
				ovf_q[cmd.coef_waddr] <= 1'b1;
			end else if (cmd.coef_we && cmd.coef_src == SRC_HI && hit_hi) begin
				ovf_q[cmd.coef_waddr] <= 1'b1;
			end
			if (cmd.unst_clr) begin
				unstable_q <= 1'b0;
			end else if (cmd.unst_chk && err_q <= 0) begin
				unstable_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out.coef_index <= 6'(cmd.out_idx);
			out.coef_value <= coef_rda_q;
			out.pred_error <= (cmd.out_last && !err_q[ERR_W-1]) ? err_q[PRED_W-1:0] : '0;
			out.last_coef <= cmd.out_last;
			out.overflow <= ovf_q[cmd.out_idx];
			out.unstable <= unstable_q;
		end
	end

	assign out.valid = out_valid_q;

endmodule
`default_nettype wire
